/* design/flexfit_pkg.sv */
// flexfit_pkg: shared types and constants for the flexpage alignment fit core
// no dependencies; imported by flexfit_cell and flexpage_alignment_fit_core
package flexfit_pkg;

   // fixed field widths
   localparam int WORD_W      = 64;
   localparam int ORDER_W     = 6;
   localparam int ORDER_COUNT = 64;

   // stream word widths, padded to whole bytes
   localparam int REQ_W = 4 * WORD_W;
   localparam int RSP_W = 136;

   // configuration register indexes
   localparam logic CSR_MIN_ORDER = 1'b0;
   localparam logic CSR_MAX_ORDER = 1'b1;

   // register reset values
   localparam logic [ORDER_W-1:0] MIN_ORDER_RESET = 6'd12;
   localparam logic [ORDER_W-1:0] MAX_ORDER_RESET = 6'd22;

   // search wave handed from one order cell to the next
   typedef struct packed {
      logic               valid;
      logic               alive;
      logic [ORDER_W-1:0] best;
   } wave_type;

   // ones in the low 'order' bits
   function automatic logic [WORD_W-1:0] low_ones(input logic [ORDER_W-1:0] order);
      logic [WORD_W-1:0] mask;
      mask = (WORD_W'(1) << order) - WORD_W'(1);
      return mask;
   endfunction

endpackage

/* design/flexfit_cell.sv */
// flexfit_cell: one order of the search row, tests the aligned block at its order
// depends on flexfit_pkg (wave_type, widths)
module flexfit_cell
   import flexfit_pkg::*;
#(
   parameter int ORDER = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  wave_type           wave_i,
   input  logic [WORD_W-1:0]  lbase,
   input  logic [WORD_W-1:0]  lstart,
   input  logic [WORD_W-1:0]  lend,
   input  logic               base_bit,
   input  logic [ORDER_W-1:0] min_order,
   output wave_type           wave_o
);

   localparam logic [ORDER_W-1:0] ORD  = ORDER_W'(ORDER);
   localparam logic [WORD_W-1:0]  SPAN = (WORD_W'(1) << ORDER) - WORD_W'(1);

   logic     fit;
   wave_type wave_in;
   wave_type wave_ff;

   // aligned block holding the local base lies inside the local region
   assign fit = ((lbase & ~SPAN) >= lstart) && ((lbase | SPAN) <= lend);

   // while both bases are still aligned to this order, take this order if it is
   // at or below the minimum or if the block fits
   always_comb begin
      wave_in       = wave_i;
      wave_in.alive = wave_i.alive && !base_bit;
      if (wave_i.alive && ((ORD <= min_order) || fit)) begin
         wave_in.best = ORD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff.valid <= 1'b0;
      end else begin
         wave_ff.valid <= wave_in.valid;
      end
      wave_ff.alive <= wave_in.alive;
      wave_ff.best  <= wave_in.best;
   end

   assign wave_o = wave_ff;

endmodule

/* design/flexpage_alignment_fit_core.sv */
// flexpage_alignment_fit_core: top level, stream ports, sums, order cell row, result word
// depends on flexfit_pkg and flexfit_cell
//
// One request word gives a local region, a remote start and an offset; one
// response word gives the chosen mapping order and both bases rounded down to
// it. The block works on one word at a time: the cycle after acceptance a
// search wave enters a row of 64 order cells and moves up one cell per clock;
// the next request is taken once the response is loaded into the output
// register, which waits while that register holds an untaken response. A
// finished response may wait in the output register while the next request
// is taken. Addresses are reduced to ADDR_WIDTH bits. The user must write the order
// limits via the csr port only while the block is idle; the block does not enforce it.
module flexpage_alignment_fit_core
   import flexfit_pkg::*;
#(
   parameter int ADDR_WIDTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   // request: local_start, local_end, remote_start, offset
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,
   // response: map_order, local_map_base, remote_map_base, zero pad
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,
   // configuration
   input  logic               csr_we,
   input  logic               csr_addr,
   input  logic [ORDER_W-1:0] csr_wdata
);

   localparam int PAD_W = RSP_W - ORDER_W - 2 * WORD_W;

   logic                  busy_ff, busy_in;
   logic                  start_ff;
   logic [ADDR_WIDTH-1:0] lstart_ff, lend_ff, lbase_ff, rbase_ff;
   logic [ORDER_W-1:0]    min_ff, max_ff;
   logic                  fin_valid_ff, fin_valid_in;
   logic [ORDER_W-1:0]    fin_order_ff, fin_order_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff;

   logic                  accept, load_rsp;
   logic [ADDR_WIDTH-1:0] in_lstart, in_lend, in_rstart, in_offset;
   logic [WORD_W-1:0]     lstart_w, lend_w, lbase_w, rbase_w, either_w;
   logic [WORD_W-1:0]     keep_mask;
   wave_type              wave [ORDER_COUNT+1];
   wave_type              last;

   // request fields reduced to the address width
   assign in_lstart = req_tdata[ADDR_WIDTH-1:0];
   assign in_lend   = req_tdata[WORD_W+ADDR_WIDTH-1:WORD_W];
   assign in_rstart = req_tdata[2*WORD_W+ADDR_WIDTH-1:2*WORD_W];
   assign in_offset = req_tdata[3*WORD_W+ADDR_WIDTH-1:3*WORD_W];

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign last       = wave[ORDER_COUNT];
   assign load_rsp   = fin_valid_ff && (!rsp_valid_ff || rsp_tready);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_ORDER_RESET;
         max_ff <= MAX_ORDER_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MIN_ORDER: min_ff <= csr_wdata;
            CSR_MAX_ORDER: max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // operand capture and base sums, held until the response is loaded
   always_ff @(posedge clock) begin
      if (accept) begin
         lstart_ff <= in_lstart;
         lend_ff   <= in_lend;
         lbase_ff  <= in_lstart + in_offset;
         rbase_ff  <= in_rstart + in_offset;
      end
   end

   assign lstart_w = WORD_W'(lstart_ff);
   assign lend_w   = WORD_W'(lend_ff);
   assign lbase_w  = WORD_W'(lbase_ff);
   assign rbase_w  = WORD_W'(rbase_ff);
   assign either_w = lbase_w | rbase_w;

   // wave enters the row at order zero
   always_comb begin
      wave[0].valid = start_ff;
      wave[0].alive = 1'b1;
      wave[0].best  = '0;
   end

   // row of order cells
   for (genvar k = 0; k < ORDER_COUNT; k++) begin : g_cell
      flexfit_cell #(
         .ORDER(k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wave_i    (wave[k]),
         .lbase     (lbase_w),
         .lstart    (lstart_w),
         .lend      (lend_w),
         .base_bit  (either_w[k]),
         .min_order (min_ff),
         .wave_o    (wave[k+1])
      );
   end

   // control next values
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (load_rsp) begin
         busy_in = 1'b0;
      end

      fin_valid_in = fin_valid_ff;
      if (last.valid) begin
         fin_valid_in = 1'b1;
      end else if (load_rsp) begin
         fin_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // final cap on the order
      fin_order_in = (last.best > max_ff) ? max_ff : last.best;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= accept;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result order and response word
   assign keep_mask = ~low_ones(fin_order_ff);

   always_ff @(posedge clock) begin
      if (last.valid) begin
         fin_order_ff <= fin_order_in;
      end
      if (load_rsp) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, rbase_w & keep_mask, lbase_w & keep_mask,
                         fin_order_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // at most one cell carries the wave
   logic [ORDER_COUNT-1:0] cell_valid;
   for (genvar k = 0; k < ORDER_COUNT; k++) begin : g_valid
      assign cell_valid[k] = wave[k+1].valid;
   end

   a_single_wave: assert property (@(posedge clock) disable iff (reset)
      $onehot0({start_ff, cell_valid}))
      else $error("more than one search wave in the cell row");

   a_fin_busy: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff |-> busy_ff)
      else $error("finished order held while not busy");

   a_wave_end: assert property (@(posedge clock) disable iff (reset)
      last.valid |-> (busy_ff && !fin_valid_ff))
      else $error("search wave finished with no free result slot");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (busy_ff && !fin_valid_ff && !(|cell_valid)))
      else $error("search started while a wave or result was pending");

endmodule
